[rtl/csrses_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrses_pkg
// shared types and constants of the sparse element store
// ----------------------------------------------------------------------------
package csrses_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int CNT_W   = 9;
    localparam int PTR_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int IDX_W   = $clog2(MAX_ROWS + 1);
    localparam int ENTRY_W = COL_W + VALUE_WIDTH;

    localparam int NUM_CELLS  = MAX_ROWS + 1;
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (NUM_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [1:0] OP_READ       = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_ACCUMULATE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK1,
        ST_LK2,
        ST_LK3,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             inc;
        logic [ROW_W-1:0] row;
    } cells_ctrl_t;

    typedef struct packed {
        logic [PTR_W-1:0] start;
        logic [PTR_W-1:0] stop;
        logic [PTR_W-1:0] total;
    } row_span_t;

endpackage
`default_nettype wire

[rtl/csrses_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrses_ram
// generic simple dual port ram, registered read
// ----------------------------------------------------------------------------
module csrses_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/csrses_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrses_cell
// one row start pointer with its own increment and lookup taps
// ----------------------------------------------------------------------------
module csrses_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [csrses_pkg::IDX_W-1:0] idx,
    input  wire csrses_pkg::cells_ctrl_t      ctrl,
    output logic      [csrses_pkg::PTR_W-1:0] start_tap,
    output logic      [csrses_pkg::PTR_W-1:0] stop_tap,
    output logic      [csrses_pkg::PTR_W-1:0] value
);
    import csrses_pkg::*;

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] row_ext;

    assign row_ext = IDX_W'(ctrl.row);

    always_comb begin
        ptr_next = ptr_reg;
        // every row start above the inserting row moves up
        if (ctrl.inc && (idx > row_ext)) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else begin
            ptr_reg <= ptr_next;
        end
    end

    assign start_tap = (idx == row_ext) ? ptr_reg : '0;
    assign stop_tap  = (idx == row_ext + IDX_W'(1)) ? ptr_reg : '0;
    assign value     = ptr_reg;
endmodule
`default_nettype wire

[rtl/csrses_row_array.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrses_row_array
// row of row start cells with a two level registered lookup tree
// ----------------------------------------------------------------------------
module csrses_row_array (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire csrses_pkg::cells_ctrl_t ctrl,
    output csrses_pkg::row_span_t        span
);
    import csrses_pkg::*;

    logic [PTR_W-1:0] start_tap [NUM_CELLS];
    logic [PTR_W-1:0] stop_tap  [NUM_CELLS];
    logic [PTR_W-1:0] value     [NUM_CELLS];
    logic [PTR_W-1:0] grp_start_reg [NUM_GROUPS];
    logic [PTR_W-1:0] grp_stop_reg  [NUM_GROUPS];
    logic [PTR_W-1:0] start_reg, stop_reg;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        csrses_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .idx       (IDX_W'(i)),
            .ctrl      (ctrl),
            .start_tap (start_tap[i]),
            .stop_tap  (stop_tap[i]),
            .value     (value[i])
        );
    end

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        always_ff @(posedge aclk) begin
            logic [PTR_W-1:0] s, e;
            s = '0;
            e = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < NUM_CELLS) begin
                    s = s | start_tap[g * GROUP_SIZE + j];
                    e = e | stop_tap[g * GROUP_SIZE + j];
                end
            end
            grp_start_reg[g] <= s;
            grp_stop_reg[g]  <= e;
        end
    end

    always_ff @(posedge aclk) begin
        logic [PTR_W-1:0] s, e;
        s = '0;
        e = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            s = s | grp_start_reg[g];
            e = e | grp_stop_reg[g];
        end
        start_reg <= s;
        stop_reg  <= e;
    end

    assign span.start = start_reg;
    assign span.stop  = stop_reg;
    // the last cell holds the number of stored entries
    assign span.total = value[NUM_CELLS-1];
endmodule
`default_nettype wire

[rtl/csr_sparse_element_store_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_element_store_unit
// compressed sparse row element store with read, write and accumulate
// ----------------------------------------------------------------------------
// One transaction at a time. An item first looks up its row through the row
// start cells, then reads and compares each entry of the addressed row that is
// scanned, with a final read state when the column is absent from the row; an
// insert then moves each stored entry after the row's end up by one, all
// through the single read and single write port of the entry ram, and writes
// the new entry. The result is then handed over, waiting while the result
// stream stalls. Row starts are cleared at reset, so no clearing pass is needed.
module csr_sparse_element_store_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // row_index[7:0], column_index[15:8], value_in[47:16]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value_out[31:0]
    output logic [2:0]       m_tuser    // entry_present[0], status[2:1]
);
    import csrses_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       row_count_reg, column_count_reg;
    logic [1:0]             op_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [VALUE_WIDTH-1:0] vin_reg;
    logic [PTR_W-1:0]       k_reg, k_next;
    logic [PTR_W-1:0]       stop_reg, stop_next;
    logic [PTR_W-1:0]       total_reg, total_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic                   pres_reg, pres_next;
    logic [1:0]             stat_reg, stat_next;
    logic                   m_valid_reg;
    logic [VALUE_WIDTH-1:0] m_data_reg;
    logic [2:0]             m_user_reg;

    cells_ctrl_t            ctrl;
    row_span_t              span;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
    logic [COL_W-1:0]       rd_col;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                   in_range, is_write, is_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign rd_col   = ram_rdata[ENTRY_W-1:VALUE_WIDTH];
    assign rd_val   = ram_rdata[VALUE_WIDTH-1:0];
    assign is_write = (op_reg == OP_WRITE);
    assign is_acc   = (op_reg == OP_ACCUMULATE);
    assign in_range = ({1'b0, row_reg} < row_count_reg) && ({1'b0, col_reg} < column_count_reg);

    csrses_row_array u_rows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .span    (span)
    );

    csrses_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= CNT_W'(MAX_ROWS);
            column_count_reg <= CNT_W'(MAX_COLS);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tuser;
            row_reg <= s_tdata[7:0];
            col_reg <= s_tdata[15:8];
            vin_reg <= s_tdata[47:16];
        end
        k_reg     <= k_next;
        stop_reg  <= stop_next;
        total_reg <= total_next;
        res_reg   <= res_next;
        pres_reg  <= pres_next;
        stat_reg  <= stat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= res_reg;
            m_user_reg <= {stat_reg, pres_reg};
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        stop_next  = stop_reg;
        total_next = total_reg;
        res_next   = res_reg;
        pres_next  = pres_reg;
        stat_next  = stat_reg;
        ctrl.inc   = 1'b0;
        ctrl.row   = row_reg;
        ram_we     = 1'b0;
        ram_waddr  = k_reg[ADDR_W-1:0];
        ram_wdata  = ram_rdata;
        ram_raddr  = k_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LK1;
                end
            end
            ST_LK1: state_next = ST_LK2;
            ST_LK2: state_next = ST_LK3;
            ST_LK3: begin
                res_next   = '0;
                pres_next  = 1'b0;
                stat_next  = STATUS_OK;
                k_next     = span.start;
                stop_next  = span.stop;
                total_next = span.total;
                if (!in_range) begin
                    stat_next  = STATUS_RANGE;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (k_reg < stop_reg) begin
                    state_next = ST_SCAN_CMP;
                end else if (!is_write && !is_acc) begin
                    state_next = ST_DONE;
                end else if (total_reg >= PTR_W'(CAPACITY)) begin
                    stat_next  = STATUS_FULL;
                    state_next = ST_DONE;
                end else begin
                    k_next     = total_reg;
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SCAN_CMP: begin
                if (rd_col == col_reg) begin
                    pres_next  = 1'b1;
                    state_next = ST_DONE;
                    if (is_write) begin
                        ram_we    = 1'b1;
                        ram_wdata = {col_reg, vin_reg};
                        res_next  = vin_reg;
                    end else if (is_acc) begin
                        ram_we    = 1'b1;
                        ram_wdata = {col_reg, rd_val + vin_reg};
                        res_next  = rd_val + vin_reg;
                    end else begin
                        res_next = rd_val;
                    end
                end else begin
                    k_next     = k_reg + PTR_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                // move later entries up by one, from the top down
                ram_raddr = ADDR_W'(k_reg - PTR_W'(1));
                if (k_reg > stop_reg) begin
                    state_next = ST_SHIFT_WR;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_SHIFT_WR: begin
                ram_we     = 1'b1;
                k_next     = k_reg - PTR_W'(1);
                state_next = ST_SHIFT_RD;
            end
            ST_INSERT: begin
                ram_we     = 1'b1;
                ram_waddr  = stop_reg[ADDR_W-1:0];
                ram_wdata  = {col_reg, vin_reg};
                ctrl.inc   = 1'b1;
                res_next   = vin_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        span.total <= PTR_W'(CAPACITY))
        else $error("stored entry count beyond capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    a_insert_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.inc |-> (span.total < PTR_W'(CAPACITY)))
        else $error("insert into a full store");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("result lost on hand-over");
endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the compressed sparse row element store: a directed
// table, then random traffic over several row and column settings, a fill to
// capacity and traffic on the full store, checked against table or predictor
// ----------------------------------------------------------------------------
module testbench;
    import csrses_pkg::*;

    localparam int CYCLE_LIMIT  = 8000000;
    localparam int INSERT_CAP   = 150;
    localparam int PHASE_ITEMS  = 110;
    localparam int HOLD_CYCLES  = 400;
    localparam int DIR_ROWS     = 20;

    typedef struct packed {
        logic [31:0] value;
        logic        present;
        logic [1:0]  status;
    } elem_res_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  code;
        logic [8:0]  a;
        logic [7:0]  col;
        logic [31:0] v;
        logic        typed;
        elem_res_t   res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // predictor state
    int unsigned row_start_m [MAX_ROWS+1];
    logic [7:0]  col_m [CAPACITY];
    logic [31:0] val_m [CAPACITY];
    int unsigned rows_m = 256;
    int unsigned cols_m = 256;

    elem_res_t   pending_q [$];
    int          errors = 0;
    int          idle_pct = 27;
    bit          hold_go = 1'b0;
    int          cyc = 0;
    stim_row_t   dir_tab [DIR_ROWS];

    csr_sparse_element_store_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned eff_count(int unsigned v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic bit elem_found(logic [7:0] row, logic [7:0] col);
        int unsigned k;
        for (k = row_start_m[row]; k < row_start_m[row+1]; k++) begin
            if (col_m[k] == col) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_elem(input logic [1:0] op, input logic [7:0] row,
                                input logic [7:0] col, input logic [31:0] v,
                                output elem_res_t r);
        int unsigned total, start, stop, pos, k;
        bit found;
        r = '{32'd0, 1'b0, STATUS_OK};
        found = 1'b0;
        pos = 0;
        if (row >= eff_count(rows_m, MAX_ROWS) || col >= eff_count(cols_m, MAX_COLS)) begin
            r.status = STATUS_RANGE;
        end else begin
            total = row_start_m[MAX_ROWS];
            start = row_start_m[row];
            stop  = row_start_m[row+1];
            for (k = start; k < stop; k++) begin
                if (!found && col_m[k] == col) begin
                    found = 1'b1;
                    pos = k;
                end
            end
            r.present = found;
            if (op == OP_WRITE || op == OP_ACCUMULATE) begin
                if (found) begin
                    val_m[pos] = (op == OP_WRITE) ? v : val_m[pos] + v;
                    r.value = val_m[pos];
                end else if (total >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    for (k = total; k > stop; k--) begin
                        col_m[k] = col_m[k-1];
                        val_m[k] = val_m[k-1];
                    end
                    col_m[stop] = col;
                    val_m[stop] = v;
                    for (k = row + 1; k <= MAX_ROWS; k++) row_start_m[k]++;
                    r.value = v;
                end
            end else if (found) begin
                r.value = val_m[pos];
            end
        end
    endtask

    task automatic send_elem(input logic [1:0] op, input logic [7:0] row, input logic [7:0] col,
                             input logic [31:0] v, input bit typed, input elem_res_t texp);
        elem_res_t r;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, col, row};
        do @(posedge aclk); while (!s_tready);
        predict_elem(op, row, col, v, r);
        pending_q.push_back(typed ? texp : r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROW_COUNT) rows_m = data;
        else cols_m = data;
    endtask

    task automatic rand_elem();
        logic [1:0] op;
        logic [7:0] row, col;
        int pick;
        pick = $urandom_range(0, 99);
        op  = (pick < 5) ? 2'd3 : 2'($urandom_range(0, 2));
        row = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        col = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        // keep occupancy low so shifts stay short
        if ((op == OP_WRITE || op == OP_ACCUMULATE) && row_start_m[MAX_ROWS] >= INSERT_CAP
                && !elem_found(row, col))
            op = OP_READ;
        send_elem(op, row, col, $urandom, 1'b0, '0);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    $display("%0t: unexpected result value %h user %b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    elem_res_t e;
                    e = pending_q.pop_front();
                    if (m_tdata !== e.value) begin
                        $display("%0t: value_out expected %h actual %h", $time, e.value, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== e.present) begin
                        $display("%0t: entry_present expected %b actual %b",
                                 $time, e.present, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[2:1] !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, m_tuser[2:1]);
                        errors++;
                    end
                end
            end
            if (hold_go && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_go = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int i, p, n;
        int unsigned phase_rows [7];
        int unsigned phase_cols [7];
        logic [7:0] r, c;
        for (i = 0; i <= MAX_ROWS; i++) row_start_m[i] = 0;

        dir_tab[0]  = '{1'b0, OP_READ,       9'd0,   8'd0,   32'd0, 1'b1,
                        '{32'd0, 1'b0, STATUS_OK}};
        dir_tab[1]  = '{1'b0, OP_WRITE,      9'd255, 8'd255, 32'h7fffffff, 1'b1,
                        '{32'h7fffffff, 1'b0, STATUS_OK}};
        dir_tab[2]  = '{1'b0, OP_READ,       9'd255, 8'd255, 32'd0, 1'b1,
                        '{32'h7fffffff, 1'b1, STATUS_OK}};
        // accumulate wraps past the positive limit
        dir_tab[3]  = '{1'b0, OP_ACCUMULATE, 9'd255, 8'd255, 32'd1, 1'b1,
                        '{32'h80000000, 1'b1, STATUS_OK}};
        dir_tab[4]  = '{1'b0, OP_WRITE,      9'd0,   8'd0,   32'h80000000, 1'b1,
                        '{32'h80000000, 1'b0, STATUS_OK}};
        dir_tab[5]  = '{1'b0, OP_ACCUMULATE, 9'd0,   8'd0,   32'hffffffff, 1'b1,
                        '{32'h7fffffff, 1'b1, STATUS_OK}};
        // unused selector behaves as a read
        dir_tab[6]  = '{1'b0, 2'd3,          9'd0,   8'd0,   32'h12345678, 1'b1,
                        '{32'h7fffffff, 1'b1, STATUS_OK}};
        dir_tab[7]  = '{1'b0, OP_ACCUMULATE, 9'd10,  8'd5,   32'hfffffffb, 1'b1,
                        '{32'hfffffffb, 1'b0, STATUS_OK}};
        dir_tab[8]  = '{1'b0, OP_WRITE,      9'd10,  8'd5,   32'd0, 1'b1,
                        '{32'd0, 1'b1, STATUS_OK}};
        dir_tab[9]  = '{1'b0, OP_WRITE,      9'd10,  8'd6,   32'h00001234, 1'b0, '0};
        dir_tab[10] = '{1'b0, OP_READ,       9'd10,  8'd7,   32'hffffffff, 1'b1,
                        '{32'd0, 1'b0, STATUS_OK}};
        dir_tab[11] = '{1'b0, OP_WRITE,      9'd0,   8'd1,   32'h0badcafe, 1'b0, '0};
        dir_tab[12] = '{1'b1, CFG_ROW_COUNT,    9'd3, 8'd0, 32'd0, 1'b0, '0};
        dir_tab[13] = '{1'b1, CFG_COLUMN_COUNT, 9'd2, 8'd0, 32'd0, 1'b0, '0};
        dir_tab[14] = '{1'b0, OP_READ,       9'd3,   8'd0,   32'd0, 1'b1,
                        '{32'd0, 1'b0, STATUS_RANGE}};
        dir_tab[15] = '{1'b0, OP_WRITE,      9'd0,   8'd2,   32'd5, 1'b1,
                        '{32'd0, 1'b0, STATUS_RANGE}};
        dir_tab[16] = '{1'b0, OP_ACCUMULATE, 9'd255, 8'd255, 32'd1, 1'b1,
                        '{32'd0, 1'b0, STATUS_RANGE}};
        dir_tab[17] = '{1'b0, OP_READ,       9'd2,   8'd1,   32'd0, 1'b1,
                        '{32'd0, 1'b0, STATUS_OK}};
        // zero count puts every coordinate out of range
        dir_tab[18] = '{1'b1, CFG_ROW_COUNT,    9'd0, 8'd0, 32'd0, 1'b0, '0};
        dir_tab[19] = '{1'b0, OP_READ,       9'd0,   8'd0,   32'd0, 1'b1,
                        '{32'd0, 1'b0, STATUS_RANGE}};

        phase_rows = '{256, 1, 511, 0, 200, 256, 1};
        phase_cols = '{256, 1, 511, 0, 37, 1, 256};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].is_cfg)
                write_reg(dir_tab[i].code, dir_tab[i].a);
            else
                send_elem(dir_tab[i].code, dir_tab[i].a[7:0], dir_tab[i].col, dir_tab[i].v,
                          dir_tab[i].typed, dir_tab[i].res);
        end

        for (p = 0; p < 8; p++) begin
            if (p < 7) begin
                write_reg(CFG_ROW_COUNT, phase_rows[p][8:0]);
                write_reg(CFG_COLUMN_COUNT, phase_cols[p][8:0]);
            end else begin
                write_reg(CFG_ROW_COUNT, 9'($urandom));
                write_reg(CFG_COLUMN_COUNT, 9'($urandom));
            end
            idle_pct = (p == 2) ? 0 : 27;
            if (p == 1 || p == 5) hold_go = 1'b1;
            n = (p == 3) ? 40 : PHASE_ITEMS;
            for (i = 0; i < n; i++) rand_elem();
        end

        // fill up to capacity, rows in ascending order
        idle_pct = 27;
        write_reg(CFG_ROW_COUNT, 9'd256);
        write_reg(CFG_COLUMN_COUNT, 9'd256);
        r = 8'd0;
        c = 8'd0;
        while (row_start_m[MAX_ROWS] < CAPACITY) begin
            send_elem(OP_WRITE, r, c, $urandom, 1'b0, '0);
            if (c == 8'd7) begin
                c = 8'd0;
                r = r + 8'd1;
            end else begin
                c = c + 8'd1;
            end
        end
        for (i = 0; i < 60; i++) begin
            send_elem(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), $urandom,
                      1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
